FILE: hw/rtl/utf8d_pkg.sv
`default_nettype none

package utf8d_pkg;

  // Byte classes
  localparam logic [7:0] CONT_MASK    = 8'b1100_0000;
  localparam logic [7:0] CONT_TAG     = 8'b1000_0000;
  localparam logic [7:0] PAYLOAD_MASK = 8'b0011_1111;
  localparam logic [7:0] LEAD6_MASK   = 8'b1111_1100;
  localparam logic [7:0] BAD_MASK     = 8'b1111_1110;

  // Configuration register map
  localparam int unsigned    PADDR_W    = 3;
  localparam logic [PADDR_W-1:0] ADDR_REPL = 3'd0;
  localparam logic [30:0]    REPL_RESET = 31'd65533;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [30:0] code_point;
    logic        last_of_run;
  } out_item_t;

  // One queue entry holds every result of one byte
  typedef struct packed {
    logic        two;
    logic [30:0] v0;
    logic [30:0] v1;
  } q_entry_t;

  typedef struct packed {
    logic       is_ascii;
    logic       bad;
    logic [2:0] rem;
    logic [5:0] val;
  } lead_t;

  // Classify a byte seen as the start of a sequence
  function automatic lead_t lead_decode(logic [7:0] b);
    lead_t l;
    l = '0;
    if (b[7] == 1'b0) begin
      l.is_ascii = 1'b1;
    end else if ((b & BAD_MASK) == BAD_MASK) begin
      l.bad = 1'b1;
    end else if ((b & LEAD6_MASK) == LEAD6_MASK) begin
      l.rem = 3'd5;
      l.val = {5'b0, b[0]};
    end else if (b[7:3] == 5'b11111) begin
      l.rem = 3'd4;
      l.val = {4'b0, b[1:0]};
    end else if (b[7:4] == 4'b1111) begin
      l.rem = 3'd3;
      l.val = {3'b0, b[2:0]};
    end else if (b[7:5] == 3'b111) begin
      l.rem = 3'd2;
      l.val = {2'b0, b[3:0]};
    end else if ((b & CONT_MASK) == CONT_MASK) begin
      l.rem = 3'd1;
      l.val = {1'b0, b[4:0]};
    end else begin
      l.bad = 1'b1;
    end
    return l;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/utf8d_front.sv
`default_nettype none

module utf8d_front
  import utf8d_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire in_item_t    item_i,
  input  wire logic [30:0] repl_i,
  output      logic        push_o,
  output      q_entry_t    entry_o
);

  logic [2:0]  pend_q, pend_d;
  logic [30:0] acc_q, acc_d;
  lead_t       lead;
  logic        cont;
  logic [2:0]  pend_dec;
  logic [30:0] acc_shift;
  logic        lead_emit;
  logic [30:0] lead_v;
  logic        any_emit;

  assign lead      = lead_decode(item_i.data_byte);
  assign cont      = (item_i.data_byte & CONT_MASK) == CONT_TAG;
  assign pend_dec  = pend_q - 3'd1;
  assign acc_shift = {acc_q[24:0], item_i.data_byte[5:0] & PAYLOAD_MASK[5:0]};

  // Result of treating the byte as a lead
  always_comb begin
    lead_emit = 1'b1;
    lead_v    = '0;
    if (lead.is_ascii) begin
      lead_v = {23'b0, item_i.data_byte};
    end else if (lead.bad) begin
      lead_v = repl_i;
    end else if (item_i.end_of_text) begin
      lead_v = {25'b0, lead.val};
    end else begin
      lead_emit = 1'b0;
    end
  end

  // Classify against the open sequence and build the queue entry
  always_comb begin
    pend_d   = pend_q;
    acc_d    = acc_q;
    entry_o  = '0;
    any_emit = 1'b0;
    if (pend_q != 3'd0 && cont) begin
      pend_d = pend_dec;
      acc_d  = acc_shift;
      if (pend_dec == 3'd0 || item_i.end_of_text) begin
        any_emit   = 1'b1;
        entry_o.v0 = acc_shift;
        pend_d     = '0;
        acc_d      = '0;
      end
    end else begin
      if (lead_emit || lead.bad) begin
        pend_d = '0;
        acc_d  = '0;
      end else begin
        pend_d = lead.rem;
        acc_d  = {25'b0, lead.val};
      end
      if (pend_q != 3'd0) begin
        any_emit    = 1'b1;
        entry_o.v0  = repl_i;
        entry_o.two = lead_emit;
        entry_o.v1  = lead_v;
      end else begin
        any_emit   = lead_emit;
        entry_o.v0 = lead_v;
      end
    end
  end

  assign push_o = accept_i && any_emit;

  // Advance decoder state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/utf8d_fifo.sv
`default_nettype none

module utf8d_fifo
  import utf8d_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t entry_i,
  input  wire logic     pop_i,
  output      logic     full_o,
  output      logic     empty_o,
  output      q_entry_t head_o
);

  q_entry_t         mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QAW:0]     cnt_q;

  assign full_o  = cnt_q == (QAW+1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/utf8d_back.sv
`default_nettype none

module utf8d_back
  import utf8d_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      head_valid_i,
  input  wire q_entry_t  head_i,
  output      logic      pop_o,
  output      logic      out_valid_o,
  input  wire logic      out_ready_i,
  output      out_item_t out_data_o
);

  logic      valid_q;
  logic      sel_q, sel_d;
  out_item_t data_q, data_d;
  logic      load;

  assign load = head_valid_i && (!valid_q || out_ready_i);

  // Pick the next result of the head entry
  always_comb begin
    data_d.code_point  = sel_q ? head_i.v1 : head_i.v0;
    data_d.last_of_run = sel_q || !head_i.two;
    pop_o              = load && data_d.last_of_run;
    sel_d              = sel_q;
    if (load) begin
      sel_d = !data_d.last_of_run;
    end
  end

  // Hold the output beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder, original lead forms of 1 to 6 bytes.
// Input channel: in_valid_i/in_ready_o with in_data_i (one raw byte plus
// an end-of-text flag). Output channel: out_valid_o/out_ready_i with
// out_data_o (one code point plus last_of_run, set on the final result
// that a byte causes). A byte causes zero, one or two results.
// Throughput: one byte per cycle while the queue is not full; the output
// gives one result per cycle while out_ready_i is high, so a byte with two
// results holds the back end until both are taken. The front writes the
// queue at the edge that accepts the byte, and the output register then
// loads from the queue head when it is free to take a new result.
// A four-entry queue sits between the byte classifier and the output
// stage; in_ready_o drops only when that queue is full, so a stalled
// receiver backs up into the queue before the input stops.
// The replacement code is set through the APB port at address 0 and
// reads back there; reset loads U+FFFD.
// Reset clears the open sequence, the queue and the output valid flag.
`default_nettype none

module utf8_stream_decoder_core
  import utf8d_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire in_item_t           in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      out_item_t          out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  logic [30:0] repl_q;
  logic        accept;
  logic        push, pop, full, empty;
  q_entry_t    entry, head;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_REPL) ? {1'b0, repl_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= REPL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_REPL) begin
      repl_q <= pwdata[30:0];
    end
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  utf8d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .repl_i   (repl_q),
    .push_o   (push),
    .entry_o  (entry)
  );

  utf8d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  utf8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/utf8d_checker.sv
`default_nettype none

module utf8d_checker
  import utf8d_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire out_item_t          out_data_o,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [PADDR_W-1:0] paddr,
  input wire logic [31:0]        pwdata,
  input wire logic [31:0]        prdata
);

  // Stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // Second result of a byte follows right after the first
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_of_run |=> out_valid_o)
    else $error("second result of a byte missing");

  // Written replacement code reads back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == ADDR_REPL
    |=> paddr != ADDR_REPL || prdata == {1'b0, $past(pwdata[30:0])})
    else $error("replacement code readback mismatch");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

`default_nettype wire
